// ----- rtl/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BPCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define BPCP_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define BPCP_ASSERT(lbl, clk, rstn, prop)

`define BPCP_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- rtl/bpcp_pkg.sv -----
package bpcp_pkg;

  localparam int PATTERN_BITS_DEF = 15;

  localparam int DELTA_W   = 5;
  localparam int CNT_W     = 6;
  localparam int PEN_W     = 16;
  localparam int POS_W     = 17;
  localparam int DIM_W     = 13;
  localparam int COLOR_W   = 8;
  localparam int PIX_W     = 12;
  localparam int AXIS_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_X     = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_UNSET = 2'd2;

  localparam logic [DIM_W-1:0] CLIP_MAX = 13'd4096;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd1024;
  localparam logic [COLOR_W-1:0] COLOR_RST  = 8'd0;

  typedef struct packed {
    logic             cand_vld;
    logic             fin;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } bpcp_req_t;

  // true when a signed position lies inside [0, lim), lim clamped to the raster max
  function automatic logic pix_visible(logic [POS_W-1:0] v, logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] l;
    l = (lim > CLIP_MAX) ? CLIP_MAX : lim;
    return !v[POS_W-1] && (v[PEN_W-1:0] < {{(PEN_W-DIM_W){1'b0}}, l});
  endfunction

endpackage

// ----- rtl/bpcp_seq.sv -----
`include "assert_macros.svh"

module bpcp_seq #(
  parameter int PATTERN_BITS = bpcp_pkg::PATTERN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [bpcp_pkg::PEN_W-1:0] in_start_x,
  input  logic signed [bpcp_pkg::PEN_W-1:0] in_start_y,
  input  logic signed [bpcp_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [bpcp_pkg::DELTA_W-1:0] in_delta_y,
  input  logic                              in_pen_up,
  input  logic [PATTERN_BITS-1:0]           in_step_bits,
  input  logic [bpcp_pkg::DIM_W-1:0]        raster_width,
  input  logic [bpcp_pkg::DIM_W-1:0]        raster_height,
  input  logic                              emit_rdy,
  output bpcp_pkg::bpcp_req_t               req
);
  import bpcp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_AXIS = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]              st_r;
  logic [PEN_W-1:0]        pen_x_r, pen_y_r;
  logic                    lsx_r;
  logic [AXIS_W-1:0]       pma_r;
  logic [POS_W-1:0]        x_r, y_r;
  logic                    xneg_r, yneg_r, diag_r, xmaj_r, up_r;
  logic [PATTERN_BITS-1:0] pat_r;
  logic [CNT_W-1:0]        cnt_r;

  logic [DELTA_W-1:0] ax, ay;
  logic [CNT_W-1:0]   count;
  logic               diag, xmaj, axis_emit, accept;
  logic               bit_x, step_x, step_y, emit_step;
  logic [POS_W-1:0]   nx, ny;

  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign ax    = in_delta_x[DELTA_W-1] ? (DELTA_W'(0) - in_delta_x) : in_delta_x;
  assign ay    = in_delta_y[DELTA_W-1] ? (DELTA_W'(0) - in_delta_y) : in_delta_y;
  assign count = {1'b0, ax} + {1'b0, ay};
  assign diag  = (ax == ay);
  assign xmaj  = (ax > ay);
  // pen pixel goes out on a non-diagonal segment if the major axis is unknown, or changes after a minor step
  assign axis_emit = !diag && (pma_r[1] ||
                     (({1'b0, lsx_r} != pma_r) && (pma_r != {1'b0, xmaj})));

  // shared step unit: one move of the pen plus the clip compare
  assign bit_x     = pat_r[PATTERN_BITS-1];
  assign step_x    = diag_r || bit_x;
  assign step_y    = diag_r || !bit_x;
  assign nx        = step_x ? (xneg_r ? x_r - POS_W'(1) : x_r + POS_W'(1)) : x_r;
  assign ny        = step_y ? (yneg_r ? y_r - POS_W'(1) : y_r + POS_W'(1)) : y_r;
  assign emit_step = diag_r || (bit_x == xmaj_r);

  always_comb begin
    req.cand_vld = 1'b0;
    req.fin      = 1'b0;
    req.x        = x_r[PIX_W-1:0];
    req.y        = y_r[PIX_W-1:0];
    case (st_r)
      S_AXIS: begin
        req.cand_vld = pix_visible(x_r, raster_width) && pix_visible(y_r, raster_height);
      end
      S_STEP: begin
        req.x        = nx[PIX_W-1:0];
        req.y        = ny[PIX_W-1:0];
        req.cand_vld = emit_step && pix_visible(nx, raster_width) &&
                       pix_visible(ny, raster_height);
      end
      S_FIN: begin
        req.fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pen_x_r <= '0;
      pen_y_r <= '0;
      lsx_r   <= 1'b0;
      pma_r   <= AXIS_UNSET;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (accept) begin
            if (in_operation == OP_MOVE) begin
              pen_x_r <= in_start_x;
              pen_y_r <= in_start_y;
              lsx_r   <= 1'b0;
              pma_r   <= AXIS_UNSET;
            end else if (count != '0) begin
              pen_x_r <= pen_x_r + PEN_W'(in_delta_x);
              pen_y_r <= pen_y_r + PEN_W'(in_delta_y);
              if (in_pen_up) begin
                lsx_r <= 1'b1;
              end else if (diag) begin
                lsx_r <= 1'b0;
              end
              if (!diag) begin
                pma_r <= xmaj ? AXIS_X : AXIS_Y;
              end
              if (axis_emit) begin
                st_r <= S_AXIS;
              end else if (in_pen_up) begin
                st_r <= S_FIN;
              end else begin
                st_r <= S_STEP;
              end
            end
          end
        end
        S_AXIS: begin
          if (emit_rdy) begin
            st_r <= up_r ? S_FIN : S_STEP;
          end
        end
        S_STEP: begin
          if (emit_rdy) begin
            if (!diag_r) begin
              lsx_r <= bit_x;
            end
            if (cnt_r == CNT_W'(1)) begin
              st_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (emit_rdy) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // working registers of the step unit
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= {pen_x_r[PEN_W-1], pen_x_r};
      y_r    <= {pen_y_r[PEN_W-1], pen_y_r};
      xneg_r <= in_delta_x[DELTA_W-1];
      yneg_r <= in_delta_y[DELTA_W-1];
      diag_r <= diag;
      xmaj_r <= xmaj;
      up_r   <= in_pen_up;
      pat_r  <= in_step_bits;
      cnt_r  <= diag ? {1'b0, ax} : count;
    end else if (st_r == S_STEP && emit_rdy) begin
      x_r   <= nx;
      y_r   <= ny;
      pat_r <= {pat_r[PATTERN_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  `BPCP_NEVER(a_step_cnt_zero, clk, rst_n, (st_r == S_STEP) && (cnt_r == '0))
  `BPCP_NEVER(a_cand_state, clk, rst_n, req.cand_vld && !((st_r == S_AXIS) || (st_r == S_STEP)))

endmodule

// ----- rtl/bpcp_emit.sv -----
`include "assert_macros.svh"

module bpcp_emit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bpcp_pkg::bpcp_req_t             req,
  input  logic [bpcp_pkg::COLOR_W-1:0]    pixel_color,
  output logic                            emit_rdy,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpcp_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [bpcp_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [bpcp_pkg::COLOR_W-1:0]    out_pixel_value,
  output logic                            out_last_pixel
);
  import bpcp_pkg::*;

  logic               out_vld_r, out_last_r;
  logic [PIX_W-1:0]   out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_val_r;
  logic               pend_vld_r;
  logic [PIX_W-1:0]   pend_x_r, pend_y_r;
  logic               load, load_last;

  // one pixel is held back so the final one of an item can carry the last flag
  assign emit_rdy  = !out_vld_r || out_ready;
  assign load      = emit_rdy && pend_vld_r && (req.cand_vld || req.fin);
  assign load_last = req.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (emit_rdy && req.cand_vld) begin
        pend_vld_r <= 1'b1;
      end else if (emit_rdy && req.fin) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_val_r  <= pixel_color;
      out_last_r <= load_last;
    end
    if (emit_rdy && req.cand_vld) begin
      pend_x_r <= req.x;
      pend_y_r <= req.y;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_value = out_val_r;
  assign out_last_pixel  = out_last_r;

  `BPCP_ASSERT(a_fin_clears, clk, rst_n, (emit_rdy && req.fin) |=> !pend_vld_r)
  `BPCP_ASSERT(a_cand_held, clk, rst_n, (emit_rdy && req.cand_vld) |=> pend_vld_r)

endmodule

// ----- rtl/bit_pattern_curve_plotter_core.sv -----
// a pixel leaves once the next pixel of its item or the end of the item is reached, so it
// passes the pending register and then the output register; items are taken only when idle
// a drawn segment makes count steps (count = |delta_x| + |delta_y|, or |delta_x| when
// diagonal), a pen-up segment none, each plus an axis-change pixel where needed;
// a move or a zero displacement makes no steps; output stalls hold the step unit
// reset: synchronous active low; pen at the origin, axis unknown, width and height 1024
module bit_pattern_curve_plotter_core #(
  parameter int PATTERN_BITS = bpcp_pkg::PATTERN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [bpcp_pkg::PEN_W-1:0]   in_start_x,
  input  logic signed [bpcp_pkg::PEN_W-1:0]   in_start_y,
  input  logic signed [bpcp_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [bpcp_pkg::DELTA_W-1:0] in_delta_y,
  input  logic                                in_pen_up,
  input  logic [PATTERN_BITS-1:0]             in_step_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpcp_pkg::PIX_W-1:0]          out_pixel_x,
  output logic [bpcp_pkg::PIX_W-1:0]          out_pixel_y,
  output logic [bpcp_pkg::COLOR_W-1:0]        out_pixel_value,
  output logic                                out_last_pixel,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpcp_pkg::DIM_W-1:0]          cfg_data
);
  import bpcp_pkg::*;

  logic [DIM_W-1:0]   width_r, height_r;
  logic [COLOR_W-1:0] color_r;
  logic               emit_rdy;
  bpcp_req_t          req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      color_r  <= COLOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_COLOR:  color_r  <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpcp_seq #(
    .PATTERN_BITS (PATTERN_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_delta_x    (in_delta_x),
    .in_delta_y    (in_delta_y),
    .in_pen_up     (in_pen_up),
    .in_step_bits  (in_step_bits),
    .raster_width  (width_r),
    .raster_height (height_r),
    .emit_rdy      (emit_rdy),
    .req           (req)
  );

  bpcp_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .pixel_color     (color_r),
    .emit_rdy        (emit_rdy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
